FILE: src/bmhq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
// No dependencies.
package bmhq_pkg;

  typedef struct packed {
    logic signed [31:0] tag;
    logic signed [31:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DN_LOAD,
    ST_DN,
    ST_FINISH
  } state_t;

endpackage

FILE: src/binary_max_heap_queue.sv
// Binary max-heap priority queue, top level: stream ports, result register.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_ram.
// A refused insert or remove goes straight to the result; otherwise the sift loop walks at most
// floor(log2(CAPACITY)) levels, one memory read-compare-write per level.
// Result is valid the cycle after the sequencer finishes; the next input is taken then.
// rst empties the heap (count only); entry memory is not cleared.
module binary_max_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // in_priority[31:0], in_tag[63:32]
  input  logic                 s_tuser,   // op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((64 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
                                          // out_priority, out_tag, occupancy, zero pad
  output logic [1:0]           m_tuser    // status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int OUT_W = ((64 + CNT_W + 7) / 8) * 8;

  bmhq_pkg::entry_t  in_entry;
  bmhq_pkg::op_t     in_op;
  logic              out_free;
  logic              res_valid;
  bmhq_pkg::status_t res_status;
  bmhq_pkg::entry_t  res_entry;
  logic [CNT_W-1:0]  res_count;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  bmhq_pkg::entry_t  mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [AW-1:0]     mem_rb;
  bmhq_pkg::entry_t  mem_qa;
  bmhq_pkg::entry_t  mem_qb;

  assign in_entry.prio = s_tdata[31:0];
  assign in_entry.tag  = s_tdata[63:32];
  assign in_op         = bmhq_pkg::op_t'(s_tuser);
  assign out_free      = !m_tvalid || m_tready;

  bmhq_ctrl #(
    .CAPACITY(CAPACITY),
    .CNT_W   (CNT_W),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (in_op),
    .in_entry  (in_entry),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_status(res_status),
    .res_entry (res_entry),
    .res_count (res_count),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .mem_ra    (mem_ra),
    .mem_rb    (mem_rb),
    .mem_qa    (mem_qa),
    .mem_qb    (mem_qb)
  );

  bmhq_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk(clk),
    .we (mem_we),
    .wa (mem_wa),
    .wd (mem_wd),
    .ra (mem_ra),
    .rb (mem_rb),
    .qa (mem_qa),
    .qb (mem_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= OUT_W'({res_count, res_entry.tag, res_entry.prio});
      m_tuser <= res_status;
    end
  end

endmodule

FILE: src/bmhq_ram.sv
// Heap entry storage: one write port, two registered read ports.
// Depends on bmhq_pkg.
module bmhq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   wa,
  input  bmhq_pkg::entry_t wd,
  input  logic [AW-1:0]   ra,
  input  logic [AW-1:0]   rb,
  output bmhq_pkg::entry_t qa,
  output bmhq_pkg::entry_t qb
);

  bmhq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

FILE: src/bmhq_ctrl.sv
// Heap sequencer: sift-up on insert, sift-down on remove, one level per cycle.
// Depends on bmhq_pkg; drives bmhq_ram.
module bmhq_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int CNT_W    = 11,
  parameter int AW       = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bmhq_pkg::op_t    in_op,
  input  bmhq_pkg::entry_t in_entry,
  input  logic             out_free,
  output logic             res_valid,
  output bmhq_pkg::status_t res_status,
  output bmhq_pkg::entry_t res_entry,
  output logic [CNT_W-1:0] res_count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_wa,
  output bmhq_pkg::entry_t mem_wd,
  output logic [AW-1:0]    mem_ra,
  output logic [AW-1:0]    mem_rb,
  input  bmhq_pkg::entry_t mem_qa,
  input  bmhq_pkg::entry_t mem_qb
);

  bmhq_pkg::state_t  state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  parent;
  logic [CNT_W:0]    child;
  bmhq_pkg::entry_t  ent;
  bmhq_pkg::entry_t  top;
  bmhq_pkg::status_t status;

  logic              accept;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  count_inc;
  logic              up_move;
  logic              last_ok;
  logic              pick_b;
  bmhq_pkg::entry_t  sel;
  logic [CNT_W:0]    cidx;
  logic              dn_stop;

  assign accept    = in_valid && in_ready;
  assign full      = count >= CNT_W'(CAPACITY);
  assign empty     = count == '0;
  assign count_inc = count + 1'b1;

  assign up_move = (pos != CNT_W'(1)) && ($signed(ent.prio) > $signed(mem_qb.prio));
  assign last_ok = child <= {1'b0, count};
  assign pick_b  = (child < {1'b0, count}) && ($signed(mem_qa.prio) < $signed(mem_qb.prio));
  assign sel     = pick_b ? mem_qb : mem_qa;
  assign cidx    = pick_b ? child + 1'b1 : child;
  assign dn_stop = !last_ok || ($signed(ent.prio) >= $signed(sel.prio));

  assign res_valid  = state == bmhq_pkg::ST_FINISH;
  assign res_status = status;
  assign res_entry  = top;
  assign res_count  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_op == bmhq_pkg::OP_INSERT && !full) begin
          count <= count_inc;
        end else if (in_op == bmhq_pkg::OP_REMOVE && !empty) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bmhq_pkg::ST_IDLE: begin
        if (accept) begin
          pos    <= count_inc;
          parent <= CNT_W'(1);
          child  <= (CNT_W+1)'(2);
          ent    <= in_entry;
          top    <= '0;
          if (in_op == bmhq_pkg::OP_INSERT) begin
            status <= full ? bmhq_pkg::STAT_FULL : bmhq_pkg::STAT_DONE;
          end else begin
            status <= empty ? bmhq_pkg::STAT_EMPTY : bmhq_pkg::STAT_DONE;
          end
        end
      end
      bmhq_pkg::ST_UP: begin
        if (up_move) begin
          pos <= pos >> 1;
        end
      end
      bmhq_pkg::ST_DN_LOAD: begin
        top <= mem_qa;
        ent <= mem_qb;
      end
      bmhq_pkg::ST_DN: begin
        if (!dn_stop) begin
          parent <= cidx[CNT_W-1:0];
          child  <= {cidx[CNT_W-1:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = AW'(pos - 1'b1);
    mem_wd     = ent;
    mem_ra     = AW'(child - 1'b1);
    mem_rb     = AW'(child);
    case (state)
      bmhq_pkg::ST_IDLE: begin
        in_ready = !rst;
        mem_ra   = '0;
        if (in_op == bmhq_pkg::OP_INSERT) begin
          mem_rb = AW'((count_inc >> 1) - 1'b1);
        end else begin
          mem_rb = AW'(count - 1'b1);
        end
        if (in_valid) begin
          if (in_op == bmhq_pkg::OP_INSERT) begin
            state_next = full ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_UP;
          end else begin
            state_next = empty ? bmhq_pkg::ST_FINISH : bmhq_pkg::ST_DN_LOAD;
          end
        end
      end
      bmhq_pkg::ST_UP: begin
        mem_we = 1'b1;
        mem_rb = AW'((pos >> 2) - 1'b1);
        if (up_move) begin
          mem_wd = mem_qb;
        end else begin
          state_next = bmhq_pkg::ST_FINISH;
        end
      end
      bmhq_pkg::ST_DN_LOAD: begin
        state_next = bmhq_pkg::ST_DN;
      end
      bmhq_pkg::ST_DN: begin
        mem_we = 1'b1;
        mem_wa = AW'(parent - 1'b1);
        mem_ra = AW'({cidx[CNT_W-1:0], 1'b0} - 1'b1);
        mem_rb = AW'({cidx[CNT_W-1:0], 1'b0});
        if (dn_stop) begin
          state_next = bmhq_pkg::ST_FINISH;
        end else begin
          mem_wd = sel;
        end
      end
      bmhq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = bmhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bmhq_checker.sv
// Port-level checks for the heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue.
module bmhq_checker #(
  parameter int CAPACITY = 1024
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [((64 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  input logic [1:0]           m_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] occ;
  assign occ = m_tdata[64 +: CNT_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmhq_pkg::STAT_EMPTY |-> m_tdata[63:0] == '0 && occ == '0)
    else $error("refused remove with data or nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmhq_pkg::STAT_FULL |-> occ == CNT_W'(CAPACITY))
    else $error("refused insert while not full");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

endmodule

bind binary_max_heap_queue bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

FILE: tb/sv/tb_binary_max_heap_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_max_heap_queue: a max-heap predictor scores
// every result transfer. Depends on bmhq_pkg and binary_max_heap_queue.
module tb_binary_max_heap_queue;

  localparam int CAPACITY = 1024;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int MW       = ((64 + OCC_W + 7) / 8) * 8;

  typedef struct {
    bmhq_pkg::status_t  status;
    logic signed [31:0] prio;
    logic signed [31:0] tag;
    logic [OCC_W-1:0]   occupancy;
  } response_t;

  class max_heap_model;
    bmhq_pkg::entry_t heap [1:CAPACITY];
    int               count;
    int               errors;
    response_t        pending_responses [$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending_count();
      return pending_responses.size();
    endfunction

    // Predicts the response to one accepted request and updates the heap copy.
    function void apply_request(bmhq_pkg::op_t op, logic signed [31:0] prio,
                                logic signed [31:0] tag);
      response_t        r;
      bmhq_pkg::entry_t e;
      bmhq_pkg::entry_t top;
      bmhq_pkg::entry_t moved;
      int               pos;
      int               parent;
      int               child;
      r.status = bmhq_pkg::STAT_DONE;
      r.prio   = '0;
      r.tag    = '0;
      if (op == bmhq_pkg::OP_INSERT) begin
        if (count >= CAPACITY) begin
          r.status = bmhq_pkg::STAT_FULL;
        end else begin
          e.prio = prio;
          e.tag  = tag;
          count++;
          pos = count;
          while (pos != 1 && $signed(e.prio) > $signed(heap[pos / 2].prio)) begin
            heap[pos] = heap[pos / 2];
            pos = pos / 2;
          end
          heap[pos] = e;
        end
      end else if (count == 0) begin
        r.status = bmhq_pkg::STAT_EMPTY;
      end else begin
        top    = heap[1];
        moved  = heap[count];
        count--;
        parent = 1;
        child  = 2;
        while (child <= count) begin
          if (child < count && $signed(heap[child].prio) < $signed(heap[child + 1].prio))
            child++;
          if ($signed(moved.prio) >= $signed(heap[child].prio))
            break;
          heap[parent] = heap[child];
          parent = child;
          child = child * 2;
        end
        heap[parent] = moved;
        r.prio = top.prio;
        r.tag  = top.tag;
      end
      r.occupancy = OCC_W'(count);
      pending_responses.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [31:0] prio, logic [31:0] tag,
                                 logic [OCC_W-1:0] occupancy);
      response_t r;
      if (pending_responses.size() == 0) begin
        $error("unexpected result transfer: status %0d", status);
        errors++;
        return;
      end
      r = pending_responses.pop_front();
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (prio !== r.prio) begin
        $error("out_priority mismatch: expected %0d, actual %0d", r.prio, $signed(prio));
        errors++;
      end
      if (tag !== r.tag) begin
        $error("out_tag mismatch: expected %0d, actual %0d", r.tag, $signed(tag));
        errors++;
      end
      if (occupancy !== r.occupancy) begin
        $error("occupancy mismatch: expected %0d, actual %0d", r.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata  = '0;   // in_priority[31:0], in_tag[63:32]
  logic          s_tuser  = 1'b0; // op
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [MW-1:0] m_tdata;         // out_priority[31:0], out_tag[63:32], occupancy, pad
  logic [1:0]    m_tuser;         // status

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  max_heap_model heap_pred = new();

  binary_max_heap_queue #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        heap_pred.check_response(m_tuser, m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[64 +: OCC_W]);
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_request(bmhq_pkg::op_t op, logic [31:0] prio, logic [31:0] tag);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {tag, prio};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    heap_pred.apply_request(op, prio, tag);
  endtask

  // Small ranges give plenty of equal keys; extremes hit the sign boundary.
  function automatic logic [31:0] pick_priority();
    logic [31:0] p;
    case ($urandom_range(0, 4))
      0: p = $urandom();
      1: p = $urandom_range(0, 7);
      2: p = -$urandom_range(1, 8);
      3: p = $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF :
             $urandom_range(0, 2) == 0 ? 32'h8000_0000 :
             $urandom_range(0, 1) == 0 ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: p = $urandom_range(0, 1023) - 512;
    endcase
    return p;
  endfunction

  task automatic send_random(int insert_pct);
    bmhq_pkg::op_t op;
    op = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_REMOVE;
    send_request(op, pick_priority(), $urandom());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty heap, single entry, extremes, equal keys
    send_request(bmhq_pkg::OP_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(bmhq_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(bmhq_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(bmhq_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(bmhq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_request(bmhq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(bmhq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 4; i++)
      send_request(bmhq_pkg::OP_INSERT, 32'd5, 32'(i + 10));
    send_request(bmhq_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(bmhq_pkg::OP_INSERT, 32'd5, 32'd20);
    repeat (10) send_request(bmhq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // no idling: fill to capacity, overflow, then deep removes
    while (heap_pred.count < CAPACITY) send_random(95);
    repeat (8) send_random(100);
    repeat (150) send_random(30);

    src_idle_pct = 85;
    sink_stall_pct = 0;
    repeat (150) send_random(50);

    src_idle_pct = 0;
    sink_stall_pct = 85;
    repeat (150) send_random(50);

    src_idle_pct = 19;
    sink_stall_pct = 19;
    repeat (150) send_random(50);

    s_tvalid <= 1'b0;
    while (heap_pred.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (heap_pred.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
